### hdl/tsb_pkg.sv
// Shared constants, command codes and queue types for the timer slot bank.
package tsb_pkg;

  // Bank size and derived widths
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  // Fixed field widths of the channels
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int DELAY_W  = 32;
  localparam int MASK_W   = 16;
  localparam int TIME_W   = 32;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SET   = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_START = 3'd4,
    CMD_DEL   = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    logic [DELAY_W-1:0]  delay;
  } entry_t;

  // Write side of the queue
  typedef struct packed {
    logic   push;
    entry_t data;
  } q_wr_t;

  // Read side of the queue
  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_rd_t;

endpackage

### hdl/tsb_if.sv
// Channel interfaces for the timer slot bank: command input and fired-mask output.
interface tsb_in_if;
  logic                           valid;
  logic                           ready;
  logic [tsb_pkg::CMD_W-1:0]      cmd;
  logic [tsb_pkg::SLOT_W-1:0]     slot;
  logic [tsb_pkg::AMOUNT_W-1:0]   amount;
  logic [tsb_pkg::DELAY_W-1:0]    delay;

  modport source (output valid, cmd, slot, amount, delay, input ready);
  modport sink   (input valid, cmd, slot, amount, delay, output ready);
endinterface

interface tsb_out_if;
  logic                           valid;
  logic                           ready;
  logic [tsb_pkg::MASK_W-1:0]     fired_mask;

  modport source (output valid, fired_mask, input ready);
  modport sink   (input valid, fired_mask, output ready);
endinterface

### hdl/tsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/tsb_front.sv
// Front end: takes command transfers, drops no-op commands, pushes the rest to the queue.
module tsb_front (
  tsb_in_if.sink        in_ch,
  input  logic          q_full,
  output tsb_pkg::q_wr_t q_wr
);
  import tsb_pkg::*;

  logic keep;

  // Classify: tick always runs, slot commands need a slot in range, other codes drop
  always_comb begin
    keep = 1'b0;
    unique case (cmd_t'(in_ch.cmd))
      CMD_TICK: keep = 1'b1;
      CMD_ADD, CMD_SET, CMD_STOP, CMD_START, CMD_DEL:
        keep = (32'(in_ch.slot) < NUM_TIMERS);
      default: keep = 1'b0;
    endcase
  end

  assign in_ch.ready      = !q_full;
  assign q_wr.push        = in_ch.valid && !q_full && keep;
  assign q_wr.data.cmd    = cmd_t'(in_ch.cmd);
  assign q_wr.data.slot   = in_ch.slot;
  assign q_wr.data.amount = in_ch.amount;
  assign q_wr.data.delay  = in_ch.delay;

endmodule

### hdl/tsb_fifo.sv
// Short command queue between front end and back end.
module tsb_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  tsb_pkg::q_wr_t  q_wr,
  input  logic            pop,
  output logic            full,
  output tsb_pkg::q_rd_t  q_rd
);
  import tsb_pkg::*;

  entry_t               buf_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r;
  logic                 do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign full       = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.data  = buf_r[rd_ptr_r];

  // Advance pointers and count on each push and pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (q_wr.push) begin
        buf_r[wr_ptr_r] <= q_wr.data;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({q_wr.push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### hdl/tsb_back.sv
// Back end: slot state, elapsed counter, deadline memory scan and fired-mask output register.
module tsb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tsb_pkg::q_rd_t q_rd,
  output logic           pop,
  tsb_out_if.source      out_ch
);
  import tsb_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                state_r;
  logic [TIME_W-1:0]     elapsed_r;
  logic [NUM_TIMERS-1:0] present_r, armed_r, mask_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  chk_vld_r;
  logic [IDX_W-1:0]      chk_idx_r;
  logic                  out_valid_r;

  entry_t                head;
  logic [NUM_TIMERS-1:0] slot_oh, pa_sh, hit_oh;
  logic                  is_present, hit, scan_last;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [TIME_W-1:0]     ram_wdata, ram_rdata, diff;
  logic [MASK_W-1:0]     fired;

  assign head       = q_rd.data;
  assign slot_oh    = NUM_TIMERS'(1) << head.slot;
  assign is_present = |(present_r & slot_oh);

  // Pop when idle; a tick waits until the previous mask is taken
  assign pop = (state_r == ST_IDLE) && q_rd.valid &&
               !((head.cmd == CMD_TICK) && out_valid_r);

  // Deadline writes: add on an absent slot clears it, set programs it
  assign ram_we    = pop && ((head.cmd == CMD_SET) ||
                             ((head.cmd == CMD_ADD) && !is_present));
  assign ram_waddr = IDX_W'(head.slot);
  assign ram_wdata = (head.cmd == CMD_SET) ? elapsed_r + head.delay : '0;
  assign ram_raddr = IDX_W'(cnt_r);

  tsb_ram #(
    .WIDTH (TIME_W),
    .DEPTH (NUM_TIMERS)
  ) u_deadline (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Check the entry read last cycle: wrap-safe compare on the difference sign
  assign diff      = elapsed_r - ram_rdata;
  assign pa_sh     = (present_r & armed_r) >> chk_idx_r;
  assign hit       = chk_vld_r && pa_sh[0] && !diff[TIME_W-1];
  assign hit_oh    = NUM_TIMERS'(hit) << chk_idx_r;
  assign scan_last = (state_r == ST_SCAN) && (cnt_r == CNT_W'(NUM_TIMERS));

  // Fit the slot mask to the output field
  always_comb begin
    fired = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_TIMERS) begin
        fired[i] = mask_r[i];
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fired_mask = fired;

  // Hold state, slot bits, scan counters and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      present_r   <= '0;
      armed_r     <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            unique case (head.cmd)
              CMD_TICK: begin
                elapsed_r <= elapsed_r + TIME_W'(head.amount);
                mask_r    <= '0;
                cnt_r     <= '0;
                chk_vld_r <= 1'b0;
                state_r   <= ST_SCAN;
              end
              CMD_ADD: begin
                if (!is_present) begin
                  present_r <= present_r | slot_oh;
                  armed_r   <= armed_r & ~slot_oh;
                end
              end
              CMD_SET: begin
                present_r <= present_r | slot_oh;
                armed_r   <= armed_r | slot_oh;
              end
              CMD_STOP:  armed_r   <= armed_r & ~slot_oh;
              CMD_START: armed_r   <= armed_r | slot_oh;
              CMD_DEL:   present_r <= present_r & ~slot_oh;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          mask_r <= mask_r | hit_oh;
          if (scan_last) begin
            chk_vld_r   <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            chk_vld_r <= 1'b1;
            chk_idx_r <= IDX_W'(cnt_r);
            cnt_r     <= cnt_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Scan counter never runs past the bank
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r <= CNT_W'(NUM_TIMERS)))
    else $error("scan counter past bank end");

  // A new tick never starts while the previous mask is pending
  a_tick_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head.cmd == CMD_TICK)) |-> !out_valid_r)
    else $error("tick started over pending mask");

  // The end of a scan presents a mask
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    scan_last |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("scan end did not present mask");

  // Deadlines change only while no scan is reading them
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("deadline write during scan");

endmodule

### hdl/timer_slot_bank_unit.sv
// Top level of the timer slot bank: front end, command queue and back end.
// A bank of NUM_TIMERS (16) timer slots sharing one 32-bit elapsed counter. Commands enter
// on in_ch (tick, add, set, stop, start, delete); only tick returns a transfer on out_ch,
// a mask of every registered, armed slot whose deadline is reached after the counter
// advance, compared wrap-safe on the sign of elapsed minus deadline. Expired slots fire on
// every tick until stopped. Unknown commands and slots beyond the bank are dropped at the
// front and cost nothing downstream. A four-entry command queue decouples input from the
// back end, so commands keep being taken while a mask waits on out_ch until the queue fills.
// In the back end a tick scans the deadline memory through its single read port, one slot
// per cycle, and no further command is taken until the scan ends. A tick also waits until
// the previous mask has been taken.
module timer_slot_bank_unit (
  input  logic       clk,
  input  logic       rst_n,
  tsb_in_if.sink     in_ch,
  tsb_out_if.source  out_ch
);
  import tsb_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  tsb_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  tsb_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  tsb_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
